// File: sv/npcd_pkg.sv
// Shared constants, types and command/status structs of the packet console demux.
package npcd_pkg;

  // Sizing
  localparam int MAX_DEPTH     = 7;
  localparam int MESSAGE_BYTES = 64;
  localparam int LVL_W         = $clog2(MAX_DEPTH + 1);
  localparam int CNT_W         = $clog2(MESSAGE_BYTES + 1);
  localparam int IDX_W         = $clog2(MESSAGE_BYTES);
  localparam int RAM_AW        = LVL_W + IDX_W;
  localparam int RAM_DEPTH     = (MAX_DEPTH + 1) * (2 ** IDX_W);

  // Port widths
  localparam int BYTE_W      = 8;
  localparam int LEVEL_W     = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 3;

  // Register reset values
  localparam logic [BYTE_W-1:0] START_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_RST   = 8'h0A;
  localparam logic [BYTE_W-1:0] PAD_RST   = 8'h0D;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD   = 2'd2;

  // Input kinds and output channels
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;
  localparam logic CHAN_CONSOLE = 1'b0;
  localparam logic CHAN_PACKAGE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_RD,
    ST_LD,
    ST_EMPTY
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_APPEND,
    OP_ROOT_OPEN,
    OP_PUSH,
    OP_LIMIT,
    OP_POP
  } op_t;

  // Controller -> datapath
  typedef struct packed {
    op_t  op;
    logic emit;
    logic capture;
    logic scan;
    logic rd;
    logic load_byte;
    logic load_empty;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic func;
    logic chunk;
    logic is_start;
    logic is_end;
    logic depth_zero;
    logic depth_max;
    logic len0_nz;
    logic scan_done;
    logic found;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

// File: sv/npcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module npcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/npcd_ctrl.sv
// Controller state machine: item decode, trim scan and result readout sequencing.
module npcd_ctrl
  import npcd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  op_t    op_dec;
  logic   emit_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item decode from captured input and nesting status
  always_comb begin
    op_dec   = OP_NONE;
    emit_dec = 1'b0;
    if (stat.func == FUNC_CLEAR) begin
      op_dec = OP_CLEAR;
    end else if (stat.depth_zero) begin
      if (stat.is_start) begin
        op_dec   = OP_ROOT_OPEN;
        emit_dec = stat.len0_nz;
      end else begin
        op_dec   = OP_APPEND;
        emit_dec = stat.chunk;
      end
    end else if (stat.is_start) begin
      op_dec = stat.depth_max ? OP_LIMIT : OP_PUSH;
    end else if (stat.is_end) begin
      op_dec   = OP_POP;
      emit_dec = 1'b1;
    end else begin
      op_dec = OP_APPEND;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        state_nxt = emit_dec ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = stat.found ? ST_RD : ST_EMPTY;
      end
      ST_RD: begin
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (stat.out_free) state_nxt = stat.emit_last ? ST_IDLE : ST_RD;
      end
      ST_EMPTY: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    cmd.op         = OP_NONE;
    in_tready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_DECODE: begin
        cmd.op   = op_dec;
        cmd.emit = emit_dec;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
      end
      ST_LD: begin
        cmd.load_byte = stat.out_free;
      end
      ST_EMPTY: begin
        cmd.load_empty = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/npcd_dp.sv
// Datapath: config registers, nesting stack, message RAM, trim scan and output register.
module npcd_dp
  import npcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [BYTE_W-1:0]      cfg_wdata,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   in_tlast,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast
);

  // Config registers
  logic [BYTE_W-1:0] start_r, end_r, pad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RST;
      end_r   <= END_RST;
      pad_r   <= PAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_START: start_r <= cfg_wdata;
        CFG_END:   end_r   <= cfg_wdata;
        CFG_PAD:   pad_r   <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // Captured input item
  logic              func_r, chunk_r;
  logic [BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_tuser;
      byte_r  <= in_tdata;
      chunk_r <= in_tlast;
    end
  end

  // Nesting stack state
  logic [LVL_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0] len_r [MAX_DEPTH+1];
  logic [CNT_W-1:0] len_nxt [MAX_DEPTH+1];
  logic [MAX_DEPTH:0] ovf_r, ovf_nxt;

  // Emission snapshot
  logic [LVL_W-1:0] elv_r, elv_nxt;
  logic             echan_r, echan_nxt;
  logic [CNT_W-1:0] elen_r, elen_nxt;
  logic             eovf_r, eovf_nxt;

  logic [CNT_W-1:0] cur_len, app_len;
  logic             cur_full, app_ovf;
  logic [LVL_W-1:0] depth_up;
  logic             ram_we;

  assign cur_len  = len_r[depth_r];
  assign cur_full = (cur_len == CNT_W'(MESSAGE_BYTES));
  assign app_len  = cur_full ? cur_len : cur_len + CNT_W'(1);
  assign app_ovf  = cur_full | ovf_r[depth_r];
  assign depth_up = depth_r + LVL_W'(1);

  // Per-item update of the stack
  always_comb begin
    depth_nxt = depth_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    elv_nxt   = depth_r;
    echan_nxt = CHAN_CONSOLE;
    elen_nxt  = cur_len;
    eovf_nxt  = ovf_r[depth_r];
    ram_we    = 1'b0;
    unique case (cmd.op)
      OP_CLEAR: begin
        depth_nxt = '0;
        for (int i = 0; i <= MAX_DEPTH; i++) begin
          len_nxt[i] = '0;
        end
        ovf_nxt = '0;
      end
      OP_APPEND: begin
        ram_we           = ~cur_full;
        len_nxt[depth_r] = app_len;
        ovf_nxt[depth_r] = app_ovf;
        elen_nxt         = app_len;
        eovf_nxt         = app_ovf;
        // chunk end on console text: emit then reopen level 0
        if (cmd.emit) begin
          len_nxt[0] = '0;
          ovf_nxt[0] = 1'b0;
        end
      end
      OP_ROOT_OPEN: begin
        elv_nxt    = '0;
        elen_nxt   = len_r[0];
        eovf_nxt   = ovf_r[0];
        len_nxt[0] = '0;
        ovf_nxt[0] = 1'b0;
        len_nxt[1] = '0;
        ovf_nxt[1] = 1'b0;
        depth_nxt  = LVL_W'(1);
      end
      OP_PUSH: begin
        len_nxt[depth_up] = '0;
        ovf_nxt[depth_up] = 1'b0;
        depth_nxt         = depth_up;
      end
      OP_LIMIT: begin
        ovf_nxt[depth_r] = 1'b1;
      end
      OP_POP: begin
        echan_nxt        = CHAN_PACKAGE;
        len_nxt[depth_r] = '0;
        ovf_nxt[depth_r] = 1'b0;
        depth_nxt        = depth_r - LVL_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      for (int i = 0; i <= MAX_DEPTH; i++) begin
        len_r[i] <= '0;
      end
      ovf_r <= '0;
    end else begin
      depth_r <= depth_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      elv_r   <= elv_nxt;
      echan_r <= echan_nxt;
      elen_r  <= elen_nxt;
      eovf_r  <= eovf_nxt;
    end
  end

  // Trim scan and readout counters
  logic [CNT_W-1:0] sidx_r;
  logic             pend_r, found_r;
  logic [IDX_W-1:0] pidx_r, eidx_r, elast_r;
  logic             issue;
  logic             ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign issue  = cmd.scan && (sidx_r != elen_r);
  assign ram_re = issue || cmd.rd;
  assign ram_raddr = cmd.rd ? {elv_r, eidx_r} : {elv_r, sidx_r[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sidx_r  <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.emit) begin
      sidx_r  <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (cmd.scan) begin
        pend_r <= issue;
        if (issue) sidx_r <= sidx_r + CNT_W'(1);
      end
      // first and last non-pad bytes bound the trimmed message
      if (pend_r && (ram_rdata != pad_r)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pidx_r <= sidx_r[IDX_W-1:0];
    end
    if (pend_r && (ram_rdata != pad_r)) begin
      elast_r <= pidx_r;
      if (!found_r) eidx_r <= pidx_r;
    end else if (cmd.load_byte) begin
      eidx_r <= eidx_r + IDX_W'(1);
    end
  end

  npcd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({depth_r, cur_len[IDX_W-1:0]}),
    .wdata (byte_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register
  logic               out_valid_r;
  logic               o_chan_r, o_empty_r, o_last_r, o_ovf_r;
  logic [LEVEL_W-1:0] o_level_r;
  logic [BYTE_W-1:0]  o_byte_r;
  logic               out_free;

  assign out_free = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_byte || cmd.load_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte || cmd.load_empty) begin
      o_chan_r  <= echan_r;
      o_level_r <= LEVEL_W'(elv_r);
      o_ovf_r   <= eovf_r;
      o_empty_r <= cmd.load_empty;
      o_byte_r  <= cmd.load_empty ? '0 : ram_rdata;
      o_last_r  <= cmd.load_empty | (eidx_r == elast_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - LEVEL_W - BYTE_W){1'b0}}, o_byte_r, o_level_r};
  assign out_tuser  = {o_ovf_r, o_empty_r, o_chan_r};
  assign out_tlast  = o_last_r;

  // Status to controller
  always_comb begin
    stat.func       = func_r;
    stat.chunk      = chunk_r;
    stat.is_start   = (byte_r == start_r);
    stat.is_end     = (byte_r == end_r);
    stat.depth_zero = (depth_r == '0);
    stat.depth_max  = (depth_r == LVL_W'(MAX_DEPTH));
    stat.len0_nz    = (len_r[0] != '0);
    stat.scan_done  = (sidx_r == elen_r) && !pend_r;
    stat.found      = found_r;
    stat.emit_last  = (eidx_r == elast_r);
    stat.out_free   = out_free;
  end

endmodule

// File: sv/nested_packet_console_demux.sv
// Top level of the nested packet / console byte-stream demultiplexer.
//
// Input stream: one byte per transfer. in_tdata = data_byte, in_tuser = func
// (0 stream byte, 1 clear all nesting state), in_tlast = chunk_end.
// Output stream: one transfer per byte of a trimmed message. out_tlast marks
// the final byte of a message; an empty message gives a single transfer with
// the empty flag set. Config: cfg_we writes cfg_wdata into register cfg_addr
// (0 start marker, 1 end marker, 2 pad byte); other indexes are ignored.
// An item that emits nothing is accepted and then decoded. An emitting item
// adds a trim scan over the buffered message of length L (one message RAM
// read per cycle, plus the registered read latency), then a RAM read and an
// output register load per output byte, or one output register load for an
// empty message. The single read port of the message RAM sets this sequence.
// in_tready is high only while the controller is idle; a new item is taken
// while the last result still sits in the output register.
// Reset (rst_n low, synchronous) clears nesting depth, all level lengths and
// overflow flags and restores the register defaults; message RAM is not cleared.
// If out_tready stays low, readout holds; once a message ends, items that emit
// nothing are still taken; the next emitting item waits with its first result.
module nested_packet_console_demux
  import npcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [BYTE_W-1:0]      cfg_wdata,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] func
  input  logic                   in_tlast,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [2:0] level, [10:3] out_byte, rest zero
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] channel, [1] empty_res, [2] overflow
  output logic                   out_tlast
);

  cmd_t  cmd;
  stat_t stat;

  npcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  npcd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // an accepted item is decoded before the next one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted in back-to-back cycles");

  // an empty message is always a single, final transfer
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("empty result without last");

  // console text is always reported at level zero
  a_console_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[2:0] == 3'd0))
    else $error("console result with nonzero level");

  // no new item while the controller is still reading out a message
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.scan) |-> !in_tready)
    else $error("input ready during readout");
`endif

endmodule
